// ===== hw/rtl/clbts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package clbts_pkg;

  // request codes on the action field
  typedef enum logic [2:0] {
    ACT_TICK      = 3'd0,
    ACT_WR_INSTR  = 3'd1,
    ACT_WR_DATA   = 3'd2,
    ACT_RD_BUSY   = 3'd3,
    ACT_RD_DATA   = 3'd4
  } action_e;

  // latched transfer kind (action minus one)
  typedef enum logic [1:0] {
    KIND_WR_INSTR = 2'd0,
    KIND_WR_DATA  = 2'd1,
    KIND_RD_BUSY  = 2'd2,
    KIND_RD_DATA  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2
  } phase_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_EIGHT_BIT = 2'd0,
    CFG_EN_HIGH   = 2'd1,
    CFG_EN_LOW    = 2'd2
  } cfg_idx_e;

  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned CfgDataBits = 16;

  localparam logic [15:0] EnHighReset = 16'd1;
  localparam logic [15:0] EnLowReset  = 16'd5;

  // pulses per transfer
  localparam logic [1:0] StepsWr8 = 2'd1;
  localparam logic [1:0] StepsWr4 = 2'd2;
  localparam logic [1:0] StepsRd8 = 2'd2;
  localparam logic [1:0] StepsRd4 = 2'd3;

endpackage

`default_nettype wire

// ===== hw/rtl/clbts_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface clbts_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] value;
  logic [7:0] bus_sample;

  modport source (output valid, output action, output value, output bus_sample, input ready);
  modport sink   (input valid, input action, input value, input bus_sample, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/clbts_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface clbts_rsp_if;
  logic       valid;
  logic       ready;
  logic       reg_select;
  logic       read_write;
  logic       enable;
  logic       bus_drive;
  logic [7:0] bus_out;
  logic       in_progress;
  logic       done_res;
  logic       status;
  logic [7:0] read_byte;
  logic       busy_flag;
  logic [6:0] address_counter;

  modport source (
    output valid, output reg_select, output read_write, output enable, output bus_drive,
    output bus_out, output in_progress, output done_res, output status, output read_byte,
    output busy_flag, output address_counter, input ready
  );
  modport sink (
    input valid, input reg_select, input read_write, input enable, input bus_drive,
    input bus_out, input in_progress, input done_res, input status, input read_byte,
    input busy_flag, input address_counter, output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/clbts_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface clbts_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [clbts_pkg::CfgIdxBits-1:0]  index;
  logic [clbts_pkg::CfgDataBits-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/char_lcd_bus_transfer_sequencer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Character LCD bus sequencer for an HD44780-style parallel interface. Every
// transaction on req_i is either a tick (carrying the sampled DB7..DB0 pins) or
// a request: write instruction, write data, read busy/address, read data. Each
// transaction yields exactly one response on rsp_o with the RS/RW/E pin levels,
// bus direction and levels, progress, done and reject status, and the last
// read results. Throughput is one transaction per clock while rsp_o is not
// stalled; each passes the input register, then the sequencer update that loads
// the response register. The sequencer advances by one step per transaction, so
// E pulse widths are counted in ticks, not clocks. A request while a transfer
// runs is rejected with status 1 and no other effect. The bus mode is latched
// when a request starts. Timing registers of 0 act as 1, and counts saturate
// at what TICK_COUNT_BITS can hold. Configuration writes are always accepted
// and must only be issued while the block is idle.
module char_lcd_bus_transfer_sequencer_core #(
  parameter int unsigned TICK_COUNT_BITS = 16
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  clbts_req_if.sink    req_i,
  clbts_rsp_if.source  rsp_o,
  clbts_cfg_if.sink    cfg_i
);
  import clbts_pkg::*;

  // configuration registers
  logic        eight_bit_q;
  logic [15:0] en_high_q;
  logic [15:0] en_low_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eight_bit_q <= 1'b0;
      en_high_q   <= EnHighReset;
      en_low_q    <= EnLowReset;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_EIGHT_BIT: eight_bit_q <= cfg_i.data[0];
        CFG_EN_HIGH:   en_high_q   <= cfg_i.data;
        CFG_EN_LOW:    en_low_q    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // input register stage
  logic       in_valid_q;
  logic [2:0] in_action_q;
  logic [7:0] in_value_q;
  logic [7:0] in_sample_q;
  logic       advance;

  // the update stage moves whenever the response slot is free or being drained
  assign advance     = in_valid_q && (!rsp_o.valid || rsp_o.ready);
  assign req_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      in_action_q <= req_i.action;
      in_value_q  <= req_i.value;
      in_sample_q <= req_i.bus_sample;
    end
  end

  // sequencer state
  phase_e                     phase_q, phase_d;
  logic [TICK_COUNT_BITS-1:0] timer_q, timer_d;
  logic [7:0]                 send_q, send_d;
  kind_e                      kind_q, kind_d;
  logic [1:0]                 steps_q, steps_d;
  logic [7:0]                 asm_q, asm_d;
  logic                       mode_q, mode_d;
  logic                       rs_q, rs_d, rw_q, rw_d, en_q, en_d, drive_q, drive_d;
  logic [7:0]                 bus_q, bus_d;
  logic [7:0]                 last_rd_q, last_rd_d;
  logic [7:0]                 last_ba_q, last_ba_d;
  logic                       done_d, status_d;

  // pulse length to counter load: zero acts as one, saturate to counter width
  function automatic logic [TICK_COUNT_BITS-1:0] load_count(input logic [15:0] ticks);
    logic [15:0] n;
    begin
      n = (ticks == 16'd0) ? 16'd0 : ticks - 16'd1;
      if ((n >> TICK_COUNT_BITS) != 16'd0) begin
        load_count = '1;
      end else begin
        load_count = TICK_COUNT_BITS'(n);
      end
    end
  endfunction

  logic       rd_req;
  logic [1:0] steps_dec;

  always_comb begin
    phase_d   = phase_q;
    timer_d   = timer_q;
    send_d    = send_q;
    kind_d    = kind_q;
    steps_d   = steps_q;
    asm_d     = asm_q;
    mode_d    = mode_q;
    rs_d      = rs_q;
    rw_d      = rw_q;
    en_d      = en_q;
    drive_d   = drive_q;
    bus_d     = bus_q;
    last_rd_d = last_rd_q;
    last_ba_d = last_ba_q;
    done_d    = 1'b0;
    status_d  = 1'b0;
    rd_req    = (in_action_q == ACT_RD_BUSY) || (in_action_q == ACT_RD_DATA);
    steps_dec = (steps_q != 2'd0) ? steps_q - 2'd1 : 2'd0;

    case (action_e'(in_action_q))
      ACT_TICK: begin
        if (phase_q != PH_IDLE) begin
          if (timer_q != '0) begin
            timer_d = timer_q - 1'b1;
          end else if (phase_q == PH_HIGH) begin
            // end of the high period
            en_d    = 1'b0;
            phase_d = PH_LOW;
            timer_d = load_count(en_low_q);
          end else begin
            // end of the low period: sample if due, then next pulse or finish
            steps_d = steps_dec;
            if (kind_q[1] && steps_dec != 2'd0) begin
              if (mode_q) begin
                asm_d = in_sample_q;
              end else if (steps_dec == 2'd2) begin
                asm_d = {in_sample_q[7:4], asm_q[3:0]};
              end else begin
                asm_d = {asm_q[7:4], in_sample_q[7:4]};
              end
            end
            if (steps_dec == 2'd0) begin
              phase_d = PH_IDLE;
              done_d  = 1'b1;
              if (kind_q == KIND_RD_BUSY) begin
                last_ba_d = asm_d;
              end else if (kind_q == KIND_RD_DATA) begin
                last_rd_d = asm_d;
              end
            end else begin
              if (!kind_q[1] && !mode_q) begin
                bus_d = {send_q[3:0], 4'h0};
              end
              en_d    = 1'b1;
              phase_d = PH_HIGH;
              timer_d = load_count(en_high_q);
            end
          end
        end
      end
      ACT_WR_INSTR, ACT_WR_DATA, ACT_RD_BUSY, ACT_RD_DATA: begin
        if (phase_q != PH_IDLE) begin
          status_d = 1'b1;
        end else begin
          kind_d  = kind_e'(2'(in_action_q - 3'd1));
          mode_d  = eight_bit_q;
          send_d  = in_value_q;
          asm_d   = 8'h00;
          rs_d    = kind_d[0];
          rw_d    = rd_req;
          drive_d = !rd_req;
          if (rd_req) begin
            bus_d   = 8'h00;
            steps_d = eight_bit_q ? StepsRd8 : StepsRd4;
          end else begin
            bus_d   = eight_bit_q ? in_value_q : {in_value_q[7:4], 4'h0};
            steps_d = eight_bit_q ? StepsWr8 : StepsWr4;
          end
          en_d    = 1'b1;
          phase_d = PH_HIGH;
          timer_d = load_count(en_high_q);
        end
      end
      default: ; // undefined action codes leave everything unchanged
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      timer_q   <= '0;
      send_q    <= 8'h00;
      kind_q    <= KIND_WR_INSTR;
      steps_q   <= 2'd0;
      asm_q     <= 8'h00;
      mode_q    <= 1'b0;
      rs_q      <= 1'b0;
      rw_q      <= 1'b0;
      en_q      <= 1'b0;
      drive_q   <= 1'b0;
      bus_q     <= 8'h00;
      last_rd_q <= 8'h00;
      last_ba_q <= 8'h00;
    end else if (advance) begin
      phase_q   <= phase_d;
      timer_q   <= timer_d;
      send_q    <= send_d;
      kind_q    <= kind_d;
      steps_q   <= steps_d;
      asm_q     <= asm_d;
      mode_q    <= mode_d;
      rs_q      <= rs_d;
      rw_q      <= rw_d;
      en_q      <= en_d;
      drive_q   <= drive_d;
      bus_q     <= bus_d;
      last_rd_q <= last_rd_d;
      last_ba_q <= last_ba_d;
    end
  end

  // response register
  logic       out_valid_q;
  logic       o_rs_q, o_rw_q, o_en_q, o_drive_q, o_prog_q, o_done_q, o_status_q;
  logic [7:0] o_bus_q, o_rd_q, o_ba_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      o_rs_q     <= rs_d;
      o_rw_q     <= rw_d;
      o_en_q     <= en_d;
      o_drive_q  <= drive_d;
      o_bus_q    <= bus_d;
      o_prog_q   <= (phase_d != PH_IDLE);
      o_done_q   <= done_d;
      o_status_q <= status_d;
      o_rd_q     <= last_rd_d;
      o_ba_q     <= last_ba_d;
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.reg_select      = o_rs_q;
  assign rsp_o.read_write      = o_rw_q;
  assign rsp_o.enable          = o_en_q;
  assign rsp_o.bus_drive       = o_drive_q;
  assign rsp_o.bus_out         = o_bus_q;
  assign rsp_o.in_progress     = o_prog_q;
  assign rsp_o.done_res        = o_done_q;
  assign rsp_o.status          = o_status_q;
  assign rsp_o.read_byte       = o_rd_q;
  assign rsp_o.busy_flag       = o_ba_q[7];
  assign rsp_o.address_counter = o_ba_q[6:0];

endmodule

`default_nettype wire

// ===== verif/lcd_seq_checker.sv =====
`timescale 1ns / 1ps

module lcd_seq_checker #(
  parameter int unsigned TICK_COUNT_BITS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  clbts_req_if        req_i,
  clbts_rsp_if        rsp_i,
  clbts_cfg_if        cfg_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);
  import clbts_pkg::*;

  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    logic       reg_select;
    logic       read_write;
    logic       enable;
    logic       bus_drive;
    logic [7:0] bus_out;
    logic       in_progress;
    logic       done_res;
    logic       status;
    logic [7:0] read_byte;
    logic       busy_flag;
    logic [6:0] address_counter;
  } pin_snapshot_t;

  // register copies
  logic        cfg_wide;
  logic [15:0] cfg_hi;
  logic [15:0] cfg_lo;

  // sequencer copy
  phase_e      seq_phase;
  logic [31:0] pulse_timer;
  logic [7:0]  tx_byte;
  kind_e       xfer_kind;
  logic [1:0]  pulses_left;
  logic [7:0]  rx_shift;
  logic        wide_bus;
  logic        pin_rs, pin_rw, pin_e, pin_drive;
  logic [7:0]  pin_bus;
  logic [7:0]  last_rd_byte;
  logic [7:0]  last_bf_ac;

  pin_snapshot_t expected_pins[$];

  function automatic logic [31:0] pulse_count(input logic [15:0] ticks);
    longint unsigned ceiling, n;
    ceiling = (64'd1 << TICK_COUNT_BITS) - 64'd1;
    n = (ticks == 16'd0) ? 64'd0 : 64'(ticks) - 64'd1;
    if (n > ceiling) n = ceiling;
    return 32'(n);
  endfunction

  function automatic string fmt_pins(input pin_snapshot_t p);
    return $sformatf({"rs %0d rw %0d e %0d drv %0d bus %02h run %0d done %0d ",
                      "status %0d rd %02h bf %0d ac %02h"},
                     p.reg_select, p.read_write, p.enable, p.bus_drive, p.bus_out,
                     p.in_progress, p.done_res, p.status, p.read_byte, p.busy_flag,
                     p.address_counter);
  endfunction

  function automatic logic kind_reads(input kind_e k);
    return (k == KIND_RD_BUSY) || (k == KIND_RD_DATA);
  endfunction

  task automatic start_transfer(input logic [2:0] act, input logic [7:0] val);
    case (act)
      ACT_WR_INSTR: xfer_kind = KIND_WR_INSTR;
      ACT_WR_DATA:  xfer_kind = KIND_WR_DATA;
      ACT_RD_BUSY:  xfer_kind = KIND_RD_BUSY;
      default:      xfer_kind = KIND_RD_DATA;
    endcase
    wide_bus  = cfg_wide;
    tx_byte   = val;
    rx_shift  = 8'h00;
    pin_rs    = (xfer_kind == KIND_WR_DATA) || (xfer_kind == KIND_RD_DATA);
    pin_rw    = kind_reads(xfer_kind);
    pin_drive = !kind_reads(xfer_kind);
    if (kind_reads(xfer_kind)) begin
      pin_bus     = 8'h00;
      pulses_left = wide_bus ? StepsRd8 : StepsRd4;
    end else begin
      pin_bus     = wide_bus ? val : {val[7:4], 4'h0};
      pulses_left = wide_bus ? StepsWr8 : StepsWr4;
    end
    pin_e       = 1'b1;
    seq_phase   = PH_HIGH;
    pulse_timer = pulse_count(cfg_hi);
  endtask

  task automatic step_pulse(input logic [7:0] sample, output logic finished);
    finished = 1'b0;
    if (pulse_timer != 32'd0) begin
      pulse_timer = pulse_timer - 32'd1;
    end else if (seq_phase == PH_HIGH) begin
      pin_e       = 1'b0;
      seq_phase   = PH_LOW;
      pulse_timer = pulse_count(cfg_lo);
    end else begin
      if (pulses_left != 2'd0) pulses_left = pulses_left - 2'd1;
      // on reads, every low period but the last one samples the bus
      if (kind_reads(xfer_kind) && pulses_left != 2'd0) begin
        if (wide_bus) rx_shift = sample;
        else if (pulses_left == 2'd2) rx_shift = {sample[7:4], rx_shift[3:0]};
        else rx_shift = {rx_shift[7:4], sample[7:4]};
      end
      if (pulses_left == 2'd0) begin
        seq_phase = PH_IDLE;
        finished  = 1'b1;
        if (xfer_kind == KIND_RD_BUSY) last_bf_ac = rx_shift;
        else if (xfer_kind == KIND_RD_DATA) last_rd_byte = rx_shift;
      end else begin
        if (!kind_reads(xfer_kind) && !wide_bus) pin_bus = {tx_byte[3:0], 4'h0};
        pin_e       = 1'b1;
        seq_phase   = PH_HIGH;
        pulse_timer = pulse_count(cfg_hi);
      end
    end
  endtask

  task automatic apply_item(input logic [2:0] act, input logic [7:0] val,
                            input logic [7:0] sample, output pin_snapshot_t snap);
    logic finished, rejected;
    finished = 1'b0;
    rejected = 1'b0;
    case (act)
      ACT_TICK: begin
        if (seq_phase != PH_IDLE) step_pulse(sample, finished);
      end
      ACT_WR_INSTR, ACT_WR_DATA, ACT_RD_BUSY, ACT_RD_DATA: begin
        if (seq_phase != PH_IDLE) rejected = 1'b1;
        else start_transfer(act, val);
      end
      default: ;
    endcase
    snap.reg_select      = pin_rs;
    snap.read_write      = pin_rw;
    snap.enable          = pin_e;
    snap.bus_drive       = pin_drive;
    snap.bus_out         = pin_bus;
    snap.in_progress     = (seq_phase != PH_IDLE);
    snap.done_res        = finished;
    snap.status          = rejected;
    snap.read_byte       = last_rd_byte;
    snap.busy_flag       = last_bf_ac[7];
    snap.address_counter = last_bf_ac[6:0];
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pin_snapshot_t got, want, next_pins;
    if (!rst_ni) begin
      cfg_wide     = 1'b0;
      cfg_hi       = EnHighReset;
      cfg_lo       = EnLowReset;
      seq_phase    = PH_IDLE;
      pulse_timer  = 32'd0;
      tx_byte      = 8'h00;
      xfer_kind    = KIND_WR_INSTR;
      pulses_left  = 2'd0;
      rx_shift     = 8'h00;
      wide_bus     = 1'b0;
      pin_rs       = 1'b0;
      pin_rw       = 1'b0;
      pin_e        = 1'b0;
      pin_drive    = 1'b0;
      pin_bus      = 8'h00;
      last_rd_byte = 8'h00;
      last_bf_ac   = 8'h00;
      expected_pins.delete();
      mismatch_count_o = 0;
      pending_o <= 0;
    end else begin
      // compare before queuing so an early response cannot match a fresh prediction
      if (rsp_i.valid && rsp_i.ready) begin
        got = '{rsp_i.reg_select, rsp_i.read_write, rsp_i.enable, rsp_i.bus_drive,
                rsp_i.bus_out, rsp_i.in_progress, rsp_i.done_res, rsp_i.status,
                rsp_i.read_byte, rsp_i.busy_flag, rsp_i.address_counter};
        if (expected_pins.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= MaxReports)
            $display("%0t: response with nothing expected: %s", $time, fmt_pins(got));
        end else begin
          want = expected_pins.pop_front();
          if (got !== want) begin
            mismatch_count_o++;
            if (mismatch_count_o <= MaxReports) begin
              $display("%0t: response mismatch", $time);
              $display("  expected %s", fmt_pins(want));
              $display("  actual   %s", fmt_pins(got));
            end
          end
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_EIGHT_BIT: cfg_wide = cfg_i.data[0];
          CFG_EN_HIGH:   cfg_hi   = cfg_i.data;
          CFG_EN_LOW:    cfg_lo   = cfg_i.data;
          default: ;
        endcase
      end
      if (req_i.valid && req_i.ready) begin
        apply_item(req_i.action, req_i.value, req_i.bus_sample, next_pins);
        expected_pins.push_back(next_pins);
      end
      pending_o <= expected_pins.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import clbts_pkg::*;

  localparam int unsigned ClkPeriod    = 8;
  localparam int unsigned TickBits     = 16;
  localparam int unsigned RandomItems  = 1550;
  localparam int unsigned Segments     = 8;
  // cycles with no transaction on any channel before the run is declared hung
  localparam int unsigned QuietLimit   = 5000;
  // response path is two registers deep; give it some margin at the end
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned NoisePct     = 6;
  // ticks spent inside the longest-timing transfer before the run ends
  localparam int unsigned LongTicks    = 48;

  // action codes the block ignores, and a register index nothing decodes
  localparam logic [2:0] ActSpareFirst = 3'd5;
  localparam logic [2:0] ActSpareLast  = 3'd7;
  localparam logic [1:0] UnusedRegIdx  = 2'd3;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // sender gap and receiver stall rates, in percent
  int unsigned snd_idle_pct  = 0;
  int unsigned rcv_stall_pct = 0;

  // what the stimulus believes the registers hold, used to size tick runs
  logic        cur_wide = 1'b0;
  logic [15:0] cur_hi   = EnHighReset;
  logic [15:0] cur_lo   = EnLowReset;

  int unsigned items_sent   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatch_count;
  int unsigned pending;

  clbts_req_if req_if ();
  clbts_rsp_if rsp_if ();
  clbts_cfg_if cfg_if ();

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  char_lcd_bus_transfer_sequencer_core #(
    .TICK_COUNT_BITS(TickBits)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // watches all three channels, predicts every response and counts mismatches
  lcd_seq_checker #(
    .TICK_COUNT_BITS(TickBits)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_i            (req_if),
    .rsp_i            (rsp_if),
    .cfg_i            (cfg_if),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  // response side: ready toggles at random per the current stall rate
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // hang detection: any handshake on any channel restarts the count
  wire any_xfer = (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
                  (cfg_if.valid && cfg_if.ready);

  always @(posedge clk_i) begin
    if (!rst_ni || any_xfer) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("char_lcd_bus_transfer_sequencer_core verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one transaction on the request channel; valid stays up across back-to-back items
  task automatic push_item(input logic [2:0] act, input logic [7:0] val,
                           input logic [7:0] smp);
    if ($urandom_range(99) < snd_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < snd_idle_pct);
    end
    req_if.valid      <= 1'b1;
    req_if.action     <= act;
    req_if.value      <= val;
    req_if.bus_sample <= smp;
    do @(posedge clk_i); while (!req_if.ready);
    // spare codes are ignored by the block and do not count as stimulus
    if (act <= ACT_RD_DATA) items_sent++;
  endtask

  // ticks with random pin samples, sprinkled with stray requests and spare codes
  task automatic tick_run(input int unsigned count, input int unsigned noise_pct);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(99) < noise_pct)
        push_item(3'($urandom_range(ACT_WR_INSTR, ActSpareLast)), 8'($urandom),
                  8'($urandom));
      push_item(ACT_TICK, 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic run_transfer(input logic [2:0] act, input logic [7:0] val,
                              input int unsigned ticks, input int unsigned noise_pct);
    push_item(act, val, 8'($urandom));
    tick_run(ticks, noise_pct);
  endtask

  // ticks needed to finish a transfer: every pulse takes high plus low ticks
  function automatic int unsigned transfer_ticks(input logic [2:0] act);
    int unsigned pulses, hi, lo;
    hi = (cur_hi == 16'd0) ? 1 : cur_hi;
    lo = (cur_lo == 16'd0) ? 1 : cur_lo;
    if (act == ACT_RD_BUSY || act == ACT_RD_DATA) pulses = cur_wide ? StepsRd8 : StepsRd4;
    else pulses = cur_wide ? StepsWr8 : StepsWr4;
    return pulses * (hi + lo);
  endfunction

  // register write only once the response pipeline has drained
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] wdata);
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (2) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= wdata;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_EIGHT_BIT: cur_wide = wdata[0];
      CFG_EN_HIGH:   cur_hi   = wdata;
      CFG_EN_LOW:    cur_lo   = wdata;
      default: ;
    endcase
  endtask

  initial begin
    int unsigned remaining, ticks, base, seg;
    logic [2:0]  act;

    req_if.valid      <= 1'b0;
    req_if.action     <= ACT_TICK;
    req_if.value      <= 8'h00;
    req_if.bus_sample <= 8'h00;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= CFG_EIGHT_BIT;
    cfg_if.data       <= 16'h0000;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // ---------------- directed part ----------------
    // ticks and spare codes while idle change nothing
    push_item(ACT_TICK, 8'hFF, 8'hFF);
    push_item(ActSpareFirst, 8'hFF, 8'hFF);
    push_item(ActSpareLast, 8'h00, 8'h00);

    // zero timing registers behave like one tick
    write_reg(CFG_EN_HIGH, 16'h0000);
    write_reg(CFG_EN_LOW, 16'h0000);

    // nibble-mode instruction write, with a request arriving mid-transfer
    push_item(ACT_WR_INSTR, 8'hFF, 8'h00);
    push_item(ACT_RD_BUSY, 8'h00, 8'hFF);
    tick_run(transfer_ticks(ACT_WR_INSTR), 0);

    // mode bit takes only bit 0 of the write data
    write_reg(CFG_EIGHT_BIT, 16'hFFFF);
    run_transfer(ACT_WR_DATA, 8'h00, transfer_ticks(ACT_WR_DATA), 0);
    run_transfer(ACT_RD_BUSY, 8'hFF, transfer_ticks(ACT_RD_BUSY), 0);

    // switch to nibble mode while a full-width read is running: the running
    // transfer keeps the latched mode
    push_item(ACT_RD_DATA, 8'h5A, 8'hA5);
    remaining = transfer_ticks(ACT_RD_DATA) - 1;
    tick_run(1, 0);
    write_reg(CFG_EIGHT_BIT, 16'hFFFE);
    tick_run(remaining, 0);

    // nibble-mode read, then a write to an index nothing decodes
    run_transfer(ACT_RD_DATA, 8'h00, transfer_ticks(ACT_RD_DATA), 0);
    write_reg(UnusedRegIdx, 16'hFFFF);

    // ---------------- random part ----------------
    // segments rotate through the flow-control mixes and re-randomize timing
    base = items_sent;
    for (seg = 0; seg < Segments; seg++) begin
      write_reg(CFG_EIGHT_BIT, 16'($urandom));
      write_reg(CFG_EN_HIGH, 16'($urandom_range(0, (seg == 5) ? 12 : 4)));
      write_reg(CFG_EN_LOW, 16'($urandom_range(0, (seg == 6) ? 12 : 6)));
      case (seg % 4)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 52; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 52; end
        default: begin snd_idle_pct = 30; rcv_stall_pct = 30; end
      endcase
      while (items_sent < base + (seg + 1) * RandomItems / Segments) begin
        act   = 3'($urandom_range(ACT_WR_INSTR, ACT_RD_DATA));
        ticks = transfer_ticks(act);
        // mostly complete transfers; now and then one is cut short so the
        // next request lands on a busy sequencer
        if ($urandom_range(9) == 0) ticks = $urandom_range(ticks - 1);
        else ticks += $urandom_range(2);
        run_transfer(act, 8'($urandom), ticks, NoisePct);
        // a few idle ticks between transfers
        tick_run($urandom_range(2), 0);
      end
    end

    // ---------------- longest pulses ----------------
    // full-width write with the widest low period; the high period is short
    // so the long low count gets loaded, and only its start is ticked through
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    write_reg(CFG_EIGHT_BIT, 16'h0001);
    write_reg(CFG_EN_HIGH, 16'h0003);
    write_reg(CFG_EN_LOW, 16'hFFFF);
    run_transfer(ACT_WR_DATA, 8'hC3, LongTicks, NoisePct);

    // drain, let the pipeline settle, then give the verdict
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("char_lcd_bus_transfer_sequencer_core verification clean");
    end else begin
      $display("char_lcd_bus_transfer_sequencer_core verification failed");
    end
    $finish;
  end

endmodule
